FILE: hw/rtl/scs_pkg.sv
package scs_pkg;

  localparam int unsigned MAX_LEN_DEF = 32;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned OP_W        = 2;

  // Command codes carried on op_i.
  localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN           = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW,
    ST_CELL_RD,
    ST_CELL_CALC,
    ST_WALK_RD,
    ST_WALK_RD2,
    ST_WALK_DEC,
    ST_TAIL_RD,
    ST_TAIL_EMIT
  } scs_state_e;

  // Flags from the shared compare unit.
  typedef struct packed {
    logic eq;
    logic gt;
  } scs_cmp_t;

endpackage

FILE: hw/rtl/scs_ram.sv
module scs_ram import scs_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/scs_alu.sv
module scs_alu import scs_pkg::*; #(
  parameter int unsigned VW = 6
) (
  input  logic [SYM_W-1:0] sym_a_i,
  input  logic [SYM_W-1:0] sym_b_i,
  input  logic [VW-1:0]    val_a_i,
  input  logic [VW-1:0]    val_b_i,
  input  logic [VW-1:0]    diag_i,
  output scs_cmp_t         cmp_o,
  output logic [VW-1:0]    cell_o
);

  // One symbol compare, one magnitude compare and one increment, shared by
  // the table fill and the walk.
  always_comb begin
    cmp_o.eq = (sym_a_i == sym_b_i);
    cmp_o.gt = (val_a_i > val_b_i);
    if (cmp_o.eq) begin
      cell_o = diag_i + VW'(1);
    end else if (cmp_o.gt) begin
      cell_o = val_a_i;
    end else begin
      cell_o = val_b_i;
    end
  end

endmodule

FILE: hw/rtl/shortest_common_supersequence.sv
// Shortest common supersequence engine.
// Commands arrive on op_i/symbol_i and are taken at a clock edge where start
// is high and busy is low. Append commands write one byte into the first or
// the second string store; a byte sent to a full string is dropped and
// remembered, and that is reported on truncated_o with every result of the
// next run. A run command fills a suffix LCS table held in a block RAM, then
// walks it and emits the supersequence one beat at a time on valid_o with
// out_symbol_o, last_o marking the final beat. A run with both strings empty
// yields one beat with empty_res_o and last_o, and busy stays low for it.
//
// The fill takes the rows in turn and, in each, every cell with one table
// read and one write through the shared compare unit, the table RAM having a
// single read port. Each walk beat taken while both strings have bytes left
// needs two table reads, each tail beat one store read. busy stays high from
// the run command until the cycle the last beat is registered, so the next
// command may be taken in the cycle that last beat is shown. Results cannot
// be held off by the receiver: each beat is valid for exactly one cycle.
// Reset empties both strings and clears the dropped-byte flag; the stores
// and the table need no clearing, since every entry used was written first.
// After every run both strings are empty again.
module shortest_common_supersequence import scs_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [OP_W-1:0]  op_i,
  input  logic [SYM_W-1:0] symbol_i,
  output logic             valid_o,
  output logic [SYM_W-1:0] out_symbol_o,
  output logic             last_o,
  output logic             empty_res_o,
  output logic             truncated_o
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned TW = 2 * IW;
  localparam int unsigned SDEPTH = 1 << IW;
  localparam int unsigned TDEPTH = 1 << TW;
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);

  scs_state_e state_q, state_d;

  logic [LW-1:0] n_q, n_d, m_q, m_d;
  logic          ovf_q, ovf_d;
  logic [LW-1:0] i_q, i_d, j_q, j_d;
  logic [LW-1:0] diag_q, diag_d, right_q, right_d, below_q, below_d;

  logic [LW-1:0] i_inc, j_inc;
  logic          i_edge, j_edge;

  // Store and table ports.
  logic             a_we, a_re, b_we, b_re, t_we, t_re;
  logic [IW-1:0]    a_raddr, b_raddr;
  logic [TW-1:0]    t_raddr;
  logic [SYM_W-1:0] a_rdata, b_rdata;
  logic [LW-1:0]    t_rdata;
  logic [LW-1:0]    below_cell, right_cell;

  // Shared compare unit.
  logic [LW-1:0] val_a, val_b, cell_v;
  scs_cmp_t      cmp;

  // Result beat.
  logic             emit, emit_last, emit_empty;
  logic [SYM_W-1:0] emit_sym;
  logic             valid_q;
  logic [SYM_W-1:0] sym_q;
  logic             last_q, empty_q, trunc_q;

  assign i_inc  = i_q + LW'(1);
  assign j_inc  = j_q + LW'(1);
  // The row below or the column to the right lies on the zero boundary.
  assign i_edge = (i_inc == n_q);
  assign j_edge = (j_inc == m_q);
  assign below_cell = i_edge ? '0 : t_rdata;
  assign right_cell = j_edge ? '0 : t_rdata;

  scs_ram #(.WIDTH(SYM_W), .DEPTH(SDEPTH)) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (n_q[IW-1:0]),
    .wdata_i (symbol_i),
    .re_i    (a_re),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  scs_ram #(.WIDTH(SYM_W), .DEPTH(SDEPTH)) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (m_q[IW-1:0]),
    .wdata_i (symbol_i),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  scs_ram #(.WIDTH(LW), .DEPTH(TDEPTH)) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i ({i_q[IW-1:0], j_q[IW-1:0]}),
    .wdata_i (cell_v),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  scs_alu #(.VW(LW)) u_alu (
    .sym_a_i (a_rdata),
    .sym_b_i (b_rdata),
    .val_a_i (val_a),
    .val_b_i (val_b),
    .diag_i  (diag_q),
    .cmp_o   (cmp),
    .cell_o  (cell_v)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      m_q     <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      m_q     <= m_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      j_q     <= j_d;
      valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    diag_q  <= diag_d;
    right_q <= right_d;
    below_q <= below_d;
    if (emit) begin
      sym_q   <= emit_sym;
      last_q  <= emit_last;
      empty_q <= emit_empty;
      trunc_q <= ovf_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    m_d        = m_q;
    ovf_d      = ovf_q;
    i_d        = i_q;
    j_d        = j_q;
    diag_d     = diag_q;
    right_d    = right_q;
    below_d    = below_q;
    a_we       = 1'b0;
    b_we       = 1'b0;
    t_we       = 1'b0;
    a_re       = 1'b0;
    b_re       = 1'b0;
    t_re       = 1'b0;
    a_raddr    = i_q[IW-1:0];
    b_raddr    = j_q[IW-1:0];
    t_raddr    = {i_inc[IW-1:0], j_q[IW-1:0]};
    val_a      = below_cell;
    val_b      = right_q;
    emit       = 1'b0;
    emit_sym   = '0;
    emit_last  = 1'b0;
    emit_empty = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (op_i)
            OP_APPEND_FIRST: begin
              if (n_q < LEN_MAX) begin
                a_we = 1'b1;
                n_d  = n_q + LW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_APPEND_SECOND: begin
              if (m_q < LEN_MAX) begin
                b_we = 1'b1;
                m_d  = m_q + LW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_RUN: begin
              i_d = '0;
              j_d = '0;
              if (n_q == '0 && m_q == '0) begin
                emit       = 1'b1;
                emit_last  = 1'b1;
                emit_empty = 1'b1;
                ovf_d      = 1'b0;
              end else if (n_q == '0 || m_q == '0) begin
                state_d = ST_TAIL_RD;
              end else begin
                i_d     = n_q - LW'(1);
                state_d = ST_ROW;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_ROW: begin
        a_re    = 1'b1;
        j_d     = m_q - LW'(1);
        diag_d  = '0;
        right_d = '0;
        state_d = ST_CELL_RD;
      end

      ST_CELL_RD: begin
        b_re    = 1'b1;
        t_re    = 1'b1;
        state_d = ST_CELL_CALC;
      end

      ST_CELL_CALC: begin
        t_we    = 1'b1;
        diag_d  = below_cell;
        right_d = cell_v;
        if (j_q == '0) begin
          if (i_q == '0) begin
            j_d     = '0;
            state_d = ST_WALK_RD;
          end else begin
            i_d     = i_q - LW'(1);
            state_d = ST_ROW;
          end
        end else begin
          j_d     = j_q - LW'(1);
          state_d = ST_CELL_RD;
        end
      end

      ST_WALK_RD: begin
        a_re    = 1'b1;
        b_re    = 1'b1;
        t_re    = 1'b1;
        state_d = ST_WALK_RD2;
      end

      ST_WALK_RD2: begin
        below_d = below_cell;
        t_re    = 1'b1;
        t_raddr = {i_q[IW-1:0], j_inc[IW-1:0]};
        state_d = ST_WALK_DEC;
      end

      ST_WALK_DEC: begin
        val_a = below_q;
        val_b = right_cell;
        emit  = 1'b1;
        if (cmp.eq) begin
          emit_sym = a_rdata;
          i_d      = i_inc;
          j_d      = j_inc;
        end else if (cmp.gt) begin
          emit_sym = a_rdata;
          i_d      = i_inc;
        end else begin
          emit_sym = b_rdata;
          j_d      = j_inc;
        end
        emit_last = (i_d == n_q) && (j_d == m_q);
        if (emit_last) begin
          n_d     = '0;
          m_d     = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end else if (i_d < n_q && j_d < m_q) begin
          state_d = ST_WALK_RD;
        end else begin
          state_d = ST_TAIL_RD;
        end
      end

      ST_TAIL_RD: begin
        if (i_q < n_q) begin
          a_re = 1'b1;
        end else begin
          b_re = 1'b1;
        end
        state_d = ST_TAIL_EMIT;
      end

      ST_TAIL_EMIT: begin
        emit = 1'b1;
        if (i_q < n_q) begin
          emit_sym = a_rdata;
          i_d      = i_inc;
        end else begin
          emit_sym = b_rdata;
          j_d      = j_inc;
        end
        emit_last = (i_d == n_q) && (j_d == m_q);
        if (emit_last) begin
          n_d     = '0;
          m_d     = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_TAIL_RD;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy         = (state_q != ST_IDLE);
  assign valid_o      = valid_q;
  assign out_symbol_o = sym_q;
  assign last_o       = last_q;
  assign empty_res_o  = empty_q;
  assign truncated_o  = trunc_q;

  // An empty-run beat is always the only, and so the last, beat.
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && empty_res_o |-> last_o)
    else $error("empty result beat without last");

  // The sequencer is back in idle by the time the final beat is shown.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> !busy)
    else $error("busy still high with final beat");

  // String lengths never pass the store capacity.
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_q <= LEN_MAX) && (m_q <= LEN_MAX))
    else $error("string length beyond capacity");

  // Walk indices stay within the strings.
  a_walk_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK_RD || state_q == ST_TAIL_RD) |-> (i_q <= n_q) && (j_q <= m_q))
    else $error("walk index past string end");

endmodule
